// ----- rtl/core/iptam_pkg.sv -----
// iptam_pkg: shared types, codes and helpers for the IPv4 text ACL matcher.
// It has no dependencies. The front, queue, back and top-level files use it.
package iptam_pkg;

  localparam int CHAR_W      = 8;
  localparam int ADDR_W      = 32;
  localparam int RULE_WORD_W = 64;
  localparam int OCTET_W     = 9;
  localparam int COUNT_W     = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int KIND_W      = 4;
  localparam int MAX_KINDED  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_FILTERED  = 2'd1;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_KINDS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_WORD0 = 3'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [OCTET_W-1:0] OCTET_MAX = 9'd255;
  localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;
  localparam logic [COUNT_W-1:0] OCTETS_FULL = 3'd4;
  localparam logic [COUNT_W-1:0] OCTETS_SAT  = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              end_of_field;
  } char_item_t;

  typedef struct packed {
    logic [1:0]        verdict;
    logic [ADDR_W-1:0] address;
  } result_item_t;

  // Parsed field handed from front to back.
  typedef struct packed {
    logic              malformed;
    logic [ADDR_W-1:0] address;
  } field_rec_t;

  typedef struct packed {
    logic [OCTET_W-1:0] octet_value;
    logic               octet_has_digit;
    logic [COUNT_W-1:0] octets_done;
    logic [ADDR_W-1:0]  address_accum;
    logic               text_started;
    logic               trailing_space_seen;
    logic               malformed_flag;
  } parse_state_t;

  function automatic parse_state_t close_octet(parse_state_t s);
    parse_state_t r;
    r = s;
    if (!s.octet_has_digit || (s.octet_value > OCTET_MAX)) begin
      r.malformed_flag = 1'b1;
    end
    r.address_accum = {s.address_accum[ADDR_W-9:0], s.octet_value[7:0]};
    if (s.octets_done < OCTETS_SAT) begin
      r.octets_done = s.octets_done + 3'd1;
    end
    r.octet_value     = '0;
    r.octet_has_digit = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/core/iptam_front.sv -----
// iptam_front: character parser; builds octets and flags malformed text.
// Pushes one field record per end of field. Depends on iptam_pkg.
module iptam_front import iptam_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_ready,
  input  char_item_t   char_item,
  output logic         push,
  output field_rec_t   push_rec,
  input  logic         queue_full
);

  parse_state_t state;
  parse_state_t state_next;
  parse_state_t after_char;
  parse_state_t after_end;
  logic         accept;
  logic         is_blank;
  logic         is_digit;
  logic [12:0]  prod;
  logic [7:0]   c;

  assign c          = char_item.text_char;
  assign char_ready = !queue_full;
  assign accept     = char_valid && char_ready;
  assign push       = accept && char_item.end_of_field;

  always_comb begin
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    prod = {1'b0, state.octet_value, 3'b000} + {3'b000, state.octet_value, 1'b0}
         + {5'd0, (c - CH_ZERO)};
    after_char = state;
    if (is_blank) begin
      if (state.text_started) begin
        after_char.trailing_space_seen = 1'b1;
      end
    end else begin
      if (state.trailing_space_seen) begin
        after_char.malformed_flag = 1'b1;
      end
      after_char.text_started = 1'b1;
      if (is_digit) begin
        after_char.octet_value     = (prod > 13'(OCTET_SAT)) ? OCTET_SAT : prod[OCTET_W-1:0];
        after_char.octet_has_digit = 1'b1;
      end else if (c == CH_DOT) begin
        after_char = close_octet(after_char);
      end else begin
        after_char.malformed_flag = 1'b1;
      end
    end
    after_end = close_octet(after_char);
    if (after_end.octets_done != OCTETS_FULL) begin
      after_end.malformed_flag = 1'b1;
    end
    push_rec.malformed = after_end.malformed_flag;
    push_rec.address   = after_end.address_accum;
    state_next = state;
    if (accept) begin
      state_next = char_item.end_of_field ? '0 : after_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/iptam_queue.sv -----
// iptam_queue: short FIFO of field records between parser and matcher.
// Depends on iptam_pkg.
module iptam_queue import iptam_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  field_rec_t push_rec,
  output logic       full,
  output logic       head_valid,
  output field_rec_t head_rec,
  input  logic       pop
);

  field_rec_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// ----- rtl/core/iptam_back.sv -----
// iptam_back: rule matcher with registered result output.
// Compares all rule slots in parallel. Depends on iptam_pkg.
module iptam_back import iptam_pkg::*; #(
  parameter int RULE_SLOTS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  field_rec_t                            head_rec,
  output logic                                  pop,
  input  logic [COUNT_W-1:0]                    rule_count,
  input  logic [KIND_W-1:0]                     rule_kinds,
  input  logic [RULE_SLOTS-1:0][RULE_WORD_W-1:0] rule_words,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output result_item_t                          result_item
);

  logic [COUNT_W-1:0]    count_eff;
  logic [RULE_SLOTS-1:0] kinds_ext;
  logic [RULE_SLOTS-1:0] hit;
  logic [ADDR_W-1:0]     lo;
  logic [ADDR_W-1:0]     hi;
  logic                  pass;
  result_item_t          res_next;

  assign pop = head_valid && (!result_valid || result_ready);

  always_comb begin
    count_eff = (rule_count > COUNT_W'(RULE_SLOTS)) ? COUNT_W'(RULE_SLOTS) : rule_count;
    kinds_ext = RULE_SLOTS'(rule_kinds);
    lo = '0;
    hi = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      lo = rule_words[i][ADDR_W-1:0];
      hi = rule_words[i][RULE_WORD_W-1:ADDR_W];
      if (kinds_ext[i]) begin
        hit[i] = (lo <= head_rec.address) && (head_rec.address <= hi);
      end else begin
        hit[i] = ((head_rec.address & hi) == (lo & hi));
      end
      hit[i] = hit[i] && (COUNT_W'(i) < count_eff);
    end
    pass = (count_eff == '0) || (|hit);
    if (head_rec.malformed) begin
      res_next.verdict = VERDICT_MALFORMED;
      res_next.address = '0;
    end else begin
      res_next.verdict = pass ? VERDICT_ACCEPT : VERDICT_FILTERED;
      res_next.address = head_rec.address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_item <= res_next;
    end
  end

endmodule

// ----- rtl/core/ipv4_text_acl_matcher_top.sv -----
// ipv4_text_acl_matcher_top: takes one character per cycle while the queue has room.
// Each field record passes from the parser into the queue, then the result register,
// where it stays until taken. The parser updates each octet combinationally and the
// matcher compares all rule slots in parallel, sustaining this rate while not stalled.
// Synchronous reset clears parse state, queue, output valid and all rule registers.
// Depends on iptam_pkg, iptam_front, iptam_queue and iptam_back.
module ipv4_text_acl_matcher_top import iptam_pkg::*; #(
  parameter int RULE_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  char_item_t             char_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_item_t           result_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [RULE_WORD_W-1:0] cfg_data
);

  logic [COUNT_W-1:0]                     rule_count;
  logic [KIND_W-1:0]                      rule_kinds;
  logic [RULE_SLOTS-1:0][RULE_WORD_W-1:0] rule_words;
  logic                                   cfg_write;
  logic                                   push;
  field_rec_t                             push_rec;
  logic                                   queue_full;
  logic                                   head_valid;
  field_rec_t                             head_rec;
  logic                                   pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      rule_kinds <= '0;
      rule_words <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_RULE_COUNT) begin
        rule_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_index == REG_RULE_KINDS) begin
        rule_kinds <= cfg_data[KIND_W-1:0];
      end
      for (int s = 0; s < RULE_SLOTS; s++) begin
        if ((s < MAX_KINDED) && (cfg_index == REG_RULE_WORD0 + CFG_INDEX_W'(s))) begin
          rule_words[s] <= cfg_data;
        end
      end
    end
  end

  iptam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .push       (push),
    .push_rec   (push_rec),
    .queue_full (queue_full)
  );

  iptam_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  iptam_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_rec     (head_rec),
    .pop          (pop),
    .rule_count   (rule_count),
    .rule_kinds   (rule_kinds),
    .rule_words   (rule_words),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule
